FILE: design/pfc_pkg.sv
// Playfair cipher package: transaction structs, opcodes, letter constants
// and the small mod-5 helpers. No dependencies.
package pfc_pkg;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [6:0] cipher_char;
    logic       second_of_pair;
  } out_item_t;

  typedef struct packed {
    logic key_place;
    logic text_load;
    logic fill_step;
    logic decide;
    logic sq_read;
    logic out_second;
  } pfc_cmd_t;

  typedef struct packed {
    logic square_ready;
    logic fill_last;
    logic pair_go;
  } pfc_sts_t;

  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_TEXT = 2'd1;
  localparam logic [1:0] OP_END  = 2'd2;

  localparam logic [4:0]  LETTER_I     = 5'd8;
  localparam logic [4:0]  LETTER_J     = 5'd9;
  localparam logic [4:0]  LETTER_X     = 5'd23;
  localparam logic [4:0]  LETTER_LAST  = 5'd25;
  localparam logic [4:0]  SQUARE_CELLS = 5'd25;
  localparam logic [25:0] USED_RESET   = 26'(1) << LETTER_J;
  localparam logic [6:0]  ASCII_A      = 7'h41;

  // {valid, letter index}; J folds to I
  function automatic logic [5:0] fold_letter(input logic [7:0] c);
    logic [7:0] idx;
    idx = 8'd0;
    if (c inside {[8'h41:8'h5A]}) begin
      idx = c - 8'h41;
    end else if (c inside {[8'h61:8'h7A]}) begin
      idx = c - 8'h61;
    end else begin
      return 6'd0;
    end
    if (idx[4:0] == LETTER_J) begin
      return {1'b1, LETTER_I};
    end
    return {1'b1, idx[4:0]};
  endfunction

  function automatic logic [2:0] div5(input logic [4:0] v);
    if (v >= 5'd20) begin
      return 3'd4;
    end else if (v >= 5'd15) begin
      return 3'd3;
    end else if (v >= 5'd10) begin
      return 3'd2;
    end else if (v >= 5'd5) begin
      return 3'd1;
    end
    return 3'd0;
  endfunction

  function automatic logic [2:0] mod5(input logic [4:0] v);
    logic [4:0] r;
    r = {2'b00, div5(v)};
    return 3'(v - ((r << 2) + r));
  endfunction

  // +1 mod 5 to encrypt, +4 mod 5 to decrypt
  function automatic logic [2:0] step5(input logic [2:0] v, input logic enc);
    if (enc) begin
      return (v == 3'd4) ? 3'd0 : 3'(v + 3'd1);
    end
    return (v == 3'd0) ? 3'd4 : 3'(v - 3'd1);
  endfunction

  function automatic logic [4:0] cell5(input logic [2:0] r, input logic [2:0] c);
    return 5'(({2'b00, r} << 2) + {2'b00, r} + {2'b00, c});
  endfunction

endpackage

FILE: design/playfair_digraph_cipher.sv
// Playfair digraph cipher top level: joins controller and datapath.
// Depends on pfc_pkg, pfc_ctrl and pfc_datapath.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall   in_data (operation, char_code)
//   out      output     out_valid / out_stall out_data (cipher_char, second_of_pair)
//   cfg      input      cfg_wr_en             cfg_wr_data (encrypt_mode)
//
// A key byte is placed as it is taken. A text or end byte takes a position read
// and, with a pair, a square read and two letters that wait on out_stall.
// The first text or end transaction after a key adds a square fill,
// one alphabet letter per cycle through the single memory write port.
// Reset is synchronous on rst_n; mode resets to encrypt, square to key phase.
// in_stall is high whenever the controller is busy, including while a
// result waits on out_stall.
module playfair_digraph_cipher
  import pfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data
);

  pfc_cmd_t cmd;
  pfc_sts_t sts;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_op     (in_data.operation),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  pfc_datapath u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_data     (in_data),
    .cmd         (cmd),
    .sts         (sts),
    .out_data    (out_data)
  );

endmodule

FILE: design/pfc_ctrl.sv
// Playfair cipher controller: sequences key placement, square fill,
// digraph lookup and the two result transactions. Depends on pfc_pkg.
module pfc_ctrl
  import pfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic [1:0] in_op,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  pfc_sts_t sts,
  output pfc_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_FILL   = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_SQRD   = 3'd3;
  localparam logic [2:0] ST_OUT1   = 3'd4;
  localparam logic [2:0] ST_OUT2   = 3'd5;

  logic [2:0] state_r, state_nxt;

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT1) || (state_r == ST_OUT2);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          case (in_op)
            OP_KEY: begin
              cmd.key_place = 1'b1;
            end
            OP_TEXT, OP_END: begin
              cmd.text_load = 1'b1;
              state_nxt     = sts.square_ready ? ST_DECIDE : ST_FILL;
            end
            default: begin
            end
          endcase
        end
      end
      ST_FILL: begin
        cmd.fill_step = 1'b1;
        if (sts.fill_last) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_nxt  = sts.pair_go ? ST_SQRD : ST_IDLE;
      end
      ST_SQRD: begin
        cmd.sq_read = 1'b1;
        state_nxt   = ST_OUT1;
      end
      ST_OUT1: begin
        if (!out_stall) begin
          state_nxt = ST_OUT2;
        end
      end
      ST_OUT2: begin
        cmd.out_second = 1'b1;
        if (!out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_no_accept_during_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input taken while a result is pending");

  a_first_then_second: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT1 && !out_stall) |=> (state_r == ST_OUT2))
    else $error("second letter did not follow the first");

  a_fill_runs: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FILL && !sts.fill_last) |=> (state_r == ST_FILL))
    else $error("square fill left early");

endmodule

FILE: design/pfc_datapath.sv
// Playfair cipher datapath: mode register, used set, key square and
// letter position memories, held letter and digraph lookup. Depends on pfc_pkg.
module pfc_datapath
  import pfc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cfg_wr_en,
  input  logic      cfg_wr_data,
  input  in_item_t  in_data,
  input  pfc_cmd_t  cmd,
  output pfc_sts_t  sts,
  output out_item_t out_data
);

  logic [4:0] key_square [0:24];
  logic [4:0] letter_position [0:25];

  logic        enc_r;
  logic [25:0] used_r, used_nxt;
  logic [4:0]  placed_r, placed_nxt;
  logic        square_ready_r, square_ready_nxt;
  logic        held_valid_r, held_valid_nxt;
  logic [4:0]  held_letter_r, held_letter_nxt;
  logic [4:0]  fill_idx_r, fill_idx_nxt;
  logic        pend_end_r, pend_ok_r;
  logic [4:0]  pend_letter_r;
  logic [4:0]  pos_p_r, pos_q_r;
  logic [4:0]  sq_x_r, sq_y_r;

  logic [5:0]  fold_in;
  logic [25:0] used_base;
  logic [4:0]  placed_base;
  logic [4:0]  place_idx;
  logic        place_en;
  logic [4:0]  pair_q;
  logic        pair_go;
  logic [2:0]  r1, c1, r2, c2;
  logic [4:0]  addr_x, addr_y;

  assign fold_in = fold_letter(in_data.char_code);

  // a key byte after text starts a new square
  assign used_base   = (cmd.key_place && square_ready_r) ? USED_RESET : used_r;
  assign placed_base = (cmd.key_place && square_ready_r) ? 5'd0 : placed_r;
  assign place_idx   = cmd.key_place ? fold_in[4:0] : fill_idx_r;
  assign place_en    = ((cmd.key_place && fold_in[5]) || cmd.fill_step)
                       && !used_base[place_idx] && (placed_base < SQUARE_CELLS);

  always_comb begin
    pair_q  = LETTER_X;
    pair_go = 1'b0;
    if (pend_end_r) begin
      pair_go = held_valid_r;
    end else if (pend_ok_r && held_valid_r) begin
      pair_go = 1'b1;
      if (!(enc_r && held_letter_r == pend_letter_r)) begin
        pair_q = pend_letter_r;
      end
    end
  end

  always_comb begin
    used_nxt         = used_r;
    placed_nxt       = placed_r;
    square_ready_nxt = square_ready_r;
    held_valid_nxt   = held_valid_r;
    held_letter_nxt  = held_letter_r;
    fill_idx_nxt     = fill_idx_r;
    if (cmd.key_place && square_ready_r) begin
      used_nxt         = USED_RESET;
      placed_nxt       = 5'd0;
      square_ready_nxt = 1'b0;
      held_valid_nxt   = 1'b0;
      held_letter_nxt  = 5'd0;
    end
    if (place_en) begin
      used_nxt   = used_base | (26'(1) << place_idx);
      placed_nxt = placed_base + 5'd1;
    end
    if (cmd.text_load) begin
      fill_idx_nxt = 5'd0;
    end
    if (cmd.fill_step) begin
      fill_idx_nxt = fill_idx_r + 5'd1;
      if (fill_idx_r == LETTER_LAST) begin
        square_ready_nxt = 1'b1;
      end
    end
    if (cmd.decide) begin
      if (pend_end_r) begin
        held_valid_nxt = 1'b0;
      end else if (pend_ok_r) begin
        if (!held_valid_r) begin
          held_valid_nxt  = 1'b1;
          held_letter_nxt = pend_letter_r;
        end else if (!(enc_r && held_letter_r == pend_letter_r)) begin
          held_valid_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enc_r          <= 1'b1;
      used_r         <= USED_RESET;
      placed_r       <= 5'd0;
      square_ready_r <= 1'b0;
      held_valid_r   <= 1'b0;
      held_letter_r  <= 5'd0;
      fill_idx_r     <= 5'd0;
    end else begin
      if (cfg_wr_en) begin
        enc_r <= cfg_wr_data;
      end
      used_r         <= used_nxt;
      placed_r       <= placed_nxt;
      square_ready_r <= square_ready_nxt;
      held_valid_r   <= held_valid_nxt;
      held_letter_r  <= held_letter_nxt;
      fill_idx_r     <= fill_idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.text_load) begin
      pend_end_r    <= (in_data.operation == OP_END);
      pend_ok_r     <= fold_in[5];
      pend_letter_r <= fold_in[4:0];
    end
  end

  always_ff @(posedge clk) begin
    if (place_en) begin
      key_square[placed_base]    <= place_idx;
      letter_position[place_idx] <= placed_base;
    end
    if (cmd.decide) begin
      pos_p_r <= letter_position[held_letter_r];
      pos_q_r <= letter_position[pair_q];
    end
  end

  always_comb begin
    r1 = div5(pos_p_r);
    c1 = mod5(pos_p_r);
    r2 = div5(pos_q_r);
    c2 = mod5(pos_q_r);
    if (r1 == r2) begin
      addr_x = cell5(r1, step5(c1, enc_r));
      addr_y = cell5(r2, step5(c2, enc_r));
    end else if (c1 == c2) begin
      addr_x = cell5(step5(r1, enc_r), c1);
      addr_y = cell5(step5(r2, enc_r), c2);
    end else begin
      addr_x = cell5(r1, c2);
      addr_y = cell5(r2, c1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sq_read) begin
      sq_x_r <= key_square[addr_x];
      sq_y_r <= key_square[addr_y];
    end
  end

  assign out_data.cipher_char    = ASCII_A + {2'b00, (cmd.out_second ? sq_y_r : sq_x_r)};
  assign out_data.second_of_pair = cmd.out_second;

  assign sts.square_ready = square_ready_r;
  assign sts.fill_last    = (fill_idx_r == LETTER_LAST);
  assign sts.pair_go      = pair_go;

  a_full_when_ready: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(square_ready_r) |-> (placed_r == SQUARE_CELLS))
    else $error("square marked ready while not full");

  a_held_never_j: assert property (@(posedge clk) disable iff (!rst_n)
    held_valid_r |-> (held_letter_r != LETTER_J))
    else $error("held letter is J");

  a_j_always_used: assert property (@(posedge clk) disable iff (!rst_n)
    used_r[LETTER_J])
    else $error("J left unmarked in used set");

endmodule

FILE: tb/tb.sv
// Self-checking testbench for playfair_digraph_cipher: drives key/text streams
// in both modes under random idling and stalls, and predicts every letter.
// Depends on pfc_pkg and the playfair_digraph_cipher RTL.
`timescale 1ns / 1ps

module tb;
  import pfc_pkg::*;

  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT = 1000000;

  class digraph_scoreboard;
    bit        encrypt;
    bit [25:0] used;
    bit [4:0]  square[25];
    bit [4:0]  cell_of[26];
    int        placed;
    bit        ready;
    bit        held_valid;
    bit [4:0]  held;
    out_item_t cipher_letters_q[$];
    int        mismatches;

    function new();
      encrypt = 1'b1;
      mismatches = 0;
      restart_square();
    endfunction

    function void restart_square();
      used = '0;
      used[LETTER_J] = 1'b1;
      placed = 0;
      ready = 1'b0;
      held_valid = 1'b0;
      held = '0;
    endfunction

    function int letter_index(bit [7:0] c);
      int idx;
      if (c >= 8'h41 && c <= 8'h5A) begin
        idx = int'(c - 8'h41);
      end else if (c >= 8'h61 && c <= 8'h7A) begin
        idx = int'(c - 8'h61);
      end else begin
        return -1;
      end
      return (idx == int'(LETTER_J)) ? int'(LETTER_I) : idx;
    endfunction

    function void place(int idx);
      if (placed >= 25 || used[idx]) return;
      used[idx] = 1'b1;
      square[placed] = 5'(idx);
      cell_of[idx] = 5'(placed);
      placed++;
    endfunction

    function void complete_square();
      if (ready) return;
      for (int i = 0; i < 26; i++) place(i);
      ready = 1'b1;
    endfunction

    function void push_digraph(bit [4:0] p, bit [4:0] q);
      int a, b, r1, c1, r2, c2, d;
      bit [4:0] x, y;
      out_item_t e;
      a = int'(cell_of[p]);
      b = int'(cell_of[q]);
      r1 = a / 5;
      c1 = a % 5;
      r2 = b / 5;
      c2 = b % 5;
      d = encrypt ? 1 : 4;
      if (r1 == r2) begin
        x = square[r1 * 5 + (c1 + d) % 5];
        y = square[r2 * 5 + (c2 + d) % 5];
      end else if (c1 == c2) begin
        x = square[((r1 + d) % 5) * 5 + c1];
        y = square[((r2 + d) % 5) * 5 + c2];
      end else begin
        x = square[r1 * 5 + c2];
        y = square[r2 * 5 + c1];
      end
      e.cipher_char = ASCII_A + {2'b00, x};
      e.second_of_pair = 1'b0;
      cipher_letters_q.push_back(e);
      e.cipher_char = ASCII_A + {2'b00, y};
      e.second_of_pair = 1'b1;
      cipher_letters_q.push_back(e);
    endfunction

    function void note_transaction(in_item_t it);
      int n;
      n = letter_index(it.char_code);
      case (it.operation)
        OP_KEY: begin
          if (ready) restart_square();
          if (n >= 0) place(n);
        end
        OP_TEXT: begin
          complete_square();
          if (n < 0) return;
          if (!held_valid) begin
            held_valid = 1'b1;
            held = 5'(n);
          end else if (encrypt && int'(held) == n) begin
            push_digraph(held, LETTER_X);
          end else begin
            held_valid = 1'b0;
            push_digraph(held, 5'(n));
          end
        end
        OP_END: begin
          complete_square();
          if (held_valid) begin
            held_valid = 1'b0;
            push_digraph(held, LETTER_X);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_letter(out_item_t got);
      out_item_t want;
      if (cipher_letters_q.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected letter, expected none got %h/%b", $time,
                 got.cipher_char, got.second_of_pair);
        return;
      end
      want = cipher_letters_q.pop_front();
      if (got.cipher_char !== want.cipher_char) begin
        mismatches++;
        $display("%0t: cipher_char mismatch, expected %h got %h", $time,
                 want.cipher_char, got.cipher_char);
      end
      if (got.second_of_pair !== want.second_of_pair) begin
        mismatches++;
        $display("%0t: second_of_pair mismatch, expected %b got %b", $time,
                 want.second_of_pair, got.second_of_pair);
      end
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic      cfg_wr_en;
  logic      cfg_wr_data;

  digraph_scoreboard board;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_left = 0;
  int cycles = 0;

  playfair_digraph_cipher uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data(out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #5 clk = ~clk;

  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_letter(out_data);
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("playfair_digraph_cipher test failed");
      $finish;
    end
  end

  task automatic send(input logic [1:0] op, input logic [7:0] code);
    in_item_t it;
    it.operation = op;
    it.char_code = code;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_transaction(it);
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (board.cipher_letters_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    board.encrypt = m;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] random_letter();
    logic [7:0] idx;
    idx = ($urandom_range(9) == 0) ? 8'd23 : 8'($urandom_range(25));
    return ($urandom_range(1) ? 8'h41 : 8'h61) + idx;
  endfunction

  task automatic send_message(inout int sent);
    int klen, tlen, r;
    logic [7:0] prev, c;
    klen = ($urandom_range(9) == 0) ? 25 : $urandom_range(8);
    for (int i = 0; i < klen; i++) begin
      c = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : random_letter();
      send(OP_KEY, c);
      sent++;
    end
    tlen = $urandom_range(1, 24);
    prev = random_letter();
    for (int i = 0; i < tlen; i++) begin
      r = $urandom_range(99);
      if (r < 15) c = prev;
      else if (r < 22) c = 8'($urandom_range(255));
      else c = random_letter();
      send(OP_TEXT, c);
      prev = c;
      sent++;
    end
    if ($urandom_range(9) < 7) begin
      send(OP_END, 8'($urandom_range(255)));
      sent++;
    end
  endtask

  task automatic run_phase(input logic m, input int tx, input int rx, input int hold);
    int sent;
    sent = 0;
    settle();
    write_mode(m);
    @(posedge clk);
    tx_idle_pct = tx;
    rx_stall_pct = rx;
    hold_left = hold;
    @(negedge clk);
    while (sent < PHASE_ITEMS) begin
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          send(2'($urandom_range(3)), 8'($urandom_range(255)));
          sent++;
        end
      end else begin
        send_message(sent);
      end
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    write_mode(1'b1);

    // key with case folding, J folding and letter-range boundary bytes
    send(OP_KEY, 8'h41);
    send(OP_KEY, 8'h7A);
    send(OP_KEY, 8'h4A);
    send(OP_KEY, 8'h6A);
    send(OP_KEY, 8'h00);
    send(OP_KEY, 8'hFF);
    send(OP_KEY, 8'h40);
    send(OP_KEY, 8'h5B);
    send(OP_KEY, 8'h60);
    send(OP_KEY, 8'h7B);
    send(OP_KEY, 8'h5A);
    send(OP_KEY, 8'h61);
    // same row, same column, doubled letter, doubled X
    send(OP_TEXT, 8'h42);
    send(OP_TEXT, 8'h64);
    send(OP_TEXT, 8'h41);
    send(OP_TEXT, 8'h6B);
    send(OP_TEXT, 8'h4C);
    send(OP_TEXT, 8'h6C);
    send(OP_TEXT, 8'h78);
    send(OP_TEXT, 8'h58);
    send(OP_NONE, 8'h58);
    send(OP_END, 8'hFF);
    send(OP_END, 8'h00);
    // key after text drops the held letter
    send(OP_TEXT, 8'h51);
    send(OP_KEY, 8'h4D);
    send(OP_END, 8'h00);

    run_phase(1'b1, 0, 0, 500);
    run_phase(1'b0, 52, 0, 0);
    run_phase(1'b1, 0, 52, 0);
    run_phase(1'b0, 34, 34, 0);
    run_phase(1'b0, 0, 0, 0);
    run_phase(1'b1, 34, 34, 0);
    run_phase(1'b1, 52, 0, 0);
    run_phase(1'b0, 0, 52, 0);
    settle();

    if (board.mismatches == 0 && board.cipher_letters_q.size() == 0) begin
      $display("playfair_digraph_cipher test passed");
    end else begin
      $display("playfair_digraph_cipher test failed");
    end
    $finish;
  end

endmodule

FILE: playfair_digraph_cipher.f
design/pfc_pkg.sv
design/pfc_ctrl.sv
design/pfc_datapath.sv
design/playfair_digraph_cipher.sv
tb/tb.sv
